// ----- hw/rtl/bap_pkg.sv -----
// Shared types and constants for the blocked-ahead proximity scan.
package bap_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned HEADING_W   = 18;

	localparam logic [CFG_INDEX_W-1:0] REG_OWN_X     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OWN_Y     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADING_X = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADING_Y = 2'd3;

	localparam logic [31:0] NEAR_LIMIT  = 32'h0004_0000;
	localparam logic [31:0] PROBE_LIMIT = 32'h0001_0000;

	typedef struct packed {
		logic signed [31:0] other_x;
		logic signed [31:0] other_y;
		logic [7:0]         car_index;
		logic               is_self;
		logic               last_car;
	} req_t;

	typedef struct packed {
		logic       blocked;
		logic [7:0] blocker_index;
	} rsp_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] car_index;
		logic       is_self;
		logic       last_car;
	} ctrl_t;

endpackage

// ----- hw/rtl/bap_dist.sv -----
// Two-stage squared distance between two 16.16 points, as 16.16 from 24.8 differences, wrapping at 32 bits.
module bap_dist (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] ax,
	input  logic [31:0] ay,
	input  logic [31:0] bx,
	input  logic [31:0] by,
	output logic [31:0] dist_sq
);

	logic [31:0] diff_x;
	logic [31:0] diff_y;
	logic [31:0] dx_s1;
	logic [31:0] dy_s1;
	logic [31:0] prod_x;
	logic [31:0] prod_y;
	logic [31:0] sqx_s2;
	logic [31:0] sqy_s2;

	assign diff_x = ax - bx;
	assign diff_y = ay - by;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 32'($signed(diff_x) >>> 8);
			dy_s1 <= 32'($signed(diff_y) >>> 8);
		end
	end

	// only the low word of each square is kept
	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= prod_x;
			sqy_s2 <= prod_y;
		end
	end

	assign dist_sq = sqy_s2 + sqx_s2;

endmodule

// ----- hw/rtl/blocked_ahead_proximity_scan.sv -----
// Top level of the blocked-ahead proximity scan.
// One vehicle record is taken per cycle unless the pipeline holds. Each record
// passes two register stages (coordinate differences, then their squares);
// the distance compares and the last-hit register update follow the second
// stage, where the record marked last loads the result register, which then
// offers the result. The pipeline holds only while a last record waits behind
// a result that has not been taken; other records keep flowing.
module blocked_ahead_proximity_scan (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bap_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [bap_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  bap_pkg::req_t                        req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output bap_pkg::rsp_t                        rsp
);

	logic [31:0]                    own_x_q;
	logic [31:0]                    own_y_q;
	logic [bap_pkg::HEADING_W-1:0]  heading_x_q;
	logic [bap_pkg::HEADING_W-1:0]  heading_y_q;
	logic [31:0]                    probe_x;
	logic [31:0]                    probe_y;
	bap_pkg::ctrl_t                 ctrl_s1;
	bap_pkg::ctrl_t                 ctrl_s2;
	logic                           adv;
	logic [31:0]                    near_sq;
	logic [31:0]                    probe_sq;
	logic                           near_ok;
	logic                           probe_ok;
	logic                           hit;
	logic                           hit_valid_q;
	logic [7:0]                     hit_index_q;
	logic                           next_valid;
	logic [7:0]                     next_index;
	logic                           emit;
	logic                           rsp_valid_q;
	bap_pkg::rsp_t                  rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_x_q     <= '0;
			own_y_q     <= '0;
			heading_x_q <= '0;
			heading_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bap_pkg::REG_OWN_X:     own_x_q     <= cfg_wdata;
				bap_pkg::REG_OWN_Y:     own_y_q     <= cfg_wdata;
				bap_pkg::REG_HEADING_X: heading_x_q <= cfg_wdata[bap_pkg::HEADING_W-1:0];
				bap_pkg::REG_HEADING_Y: heading_y_q <= cfg_wdata[bap_pkg::HEADING_W-1:0];
				default: ;
			endcase
		end
	end

	assign probe_x = own_x_q + {{(32-bap_pkg::HEADING_W){heading_x_q[bap_pkg::HEADING_W-1]}},
		heading_x_q};
	assign probe_y = own_y_q + {{(32-bap_pkg::HEADING_W){heading_y_q[bap_pkg::HEADING_W-1]}},
		heading_y_q};

	// hold only when a last record cannot hand over its result
	assign adv       = !(ctrl_s2.valid && ctrl_s2.last_car && rsp_valid_q && !rsp_ready);
	assign req_ready = adv;

	bap_dist u_near (
		.clk     (clk),
		.en      (adv),
		.ax      (own_x_q),
		.ay      (own_y_q),
		.bx      (req.other_x),
		.by      (req.other_y),
		.dist_sq (near_sq)
	);

	bap_dist u_probe (
		.clk     (clk),
		.en      (adv),
		.ax      (probe_x),
		.ay      (probe_y),
		.bx      (req.other_x),
		.by      (req.other_y),
		.dist_sq (probe_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s1.valid     <= req_valid;
			ctrl_s1.car_index <= req.car_index;
			ctrl_s1.is_self   <= req.is_self;
			ctrl_s1.last_car  <= req.last_car;
			ctrl_s2           <= ctrl_s1;
		end
	end

	// a wrapped negative sum counts as close
	assign near_ok  = near_sq[31] || (near_sq <= bap_pkg::NEAR_LIMIT);
	assign probe_ok = probe_sq[31] || (probe_sq <= bap_pkg::PROBE_LIMIT);
	assign hit      = ctrl_s2.valid && !ctrl_s2.is_self && near_ok && probe_ok;

	assign next_valid = hit ? 1'b1 : hit_valid_q;
	assign next_index = hit ? ctrl_s2.car_index : hit_index_q;
	assign emit       = adv && ctrl_s2.valid && ctrl_s2.last_car;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid_q <= 1'b0;
			hit_index_q <= '0;
		end else if (emit) begin
			hit_valid_q <= 1'b0;
			hit_index_q <= '0;
		end else if (adv) begin
			hit_valid_q <= next_valid;
			hit_index_q <= next_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.blocked       <= next_valid;
			rsp_q.blocker_index <= next_valid ? next_index : 8'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_idx_zero_unblocked: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_q.blocked) |-> (rsp_q.blocker_index == 8'd0))
		else $error("blocker_index nonzero on an unblocked result");

	a_hit_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (!hit_valid_q && (hit_index_q == 8'd0)))
		else $error("hit register not cleared after result");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!hit_valid_q |-> (hit_index_q == 8'd0))
		else $error("stale hit index without a hit");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s2.valid && ctrl_s2.last_car && !adv) |=>
		(ctrl_s2.valid && ctrl_s2.last_car && rsp_valid_q))
		else $error("held last record lost");

endmodule
